// ===== hdl/vfb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the vowel formant blend: widths, anchor positions and formant tables.
// Depends on nothing; used by the top level of the block.
package vfb_pkg;

   localparam int ANCHORS  = 5;
   localparam int FORMANTS = 5;

   localparam int COORD_W = 16;   // Q1.15 coordinate
   localparam int SQ_W    = 31;   // square of a coordinate difference, Q1.30
   localparam int DEN_W   = 32;   // squared distance plus epsilon
   localparam int W_W     = 40;   // anchor weight, floor(2^62 / den)
   localparam int HZ_W    = 13;   // whole Hz
   localparam int HZ8_W   = 16;   // Hz in Q13.3
   localparam int PROD_W  = W_W + HZ8_W;
   localparam int NUM_W   = 59;   // rounded weighted sum
   localparam int TOT_W   = 43;   // sum of the weights
   localparam int Q2_W    = 17;   // blend quotient, one bit of headroom
   localparam int OUT_W   = 16;

   localparam logic [COORD_W-1:0] UNIT_Q15 = 16'd32768;
   localparam logic [DEN_W-1:0]   EPS_Q30  = 32'd6442451;
   // Upper part of 2^62 once the forty low numerator bits are split off.
   localparam logic [DEN_W-1:0]   DIV1_REM = 32'd4194304;

   localparam logic [COORD_W-1:0] ANCHOR_X [ANCHORS] = '{
      16'd32768, 16'd28836, 16'd16384, 16'd3932, 16'd0};
   localparam logic [COORD_W-1:0] ANCHOR_Y [ANCHORS] = '{
      16'd0, 16'd16384, 16'd32768, 16'd16384, 16'd0};

   // Formant frequencies in whole Hz, indexed [anchor][formant].
   localparam logic [HZ_W-1:0] FEMALE_HZ [ANCHORS][FORMANTS] = '{
      '{13'd310, 13'd2790, 13'd3310, 13'd3900, 13'd4950},
      '{13'd610, 13'd2330, 13'd2990, 13'd3800, 13'd4950},
      '{13'd850, 13'd1220, 13'd2810, 13'd3650, 13'd4950},
      '{13'd450, 13'd900,  13'd2700, 13'd3600, 13'd4900},
      '{13'd350, 13'd800,  13'd2650, 13'd3550, 13'd4850}};

   localparam logic [HZ_W-1:0] MALE_HZ [ANCHORS][FORMANTS] = '{
      '{13'd290, 13'd2270, 13'd2980, 13'd3400, 13'd4400},
      '{13'd530, 13'd1840, 13'd2480, 13'd3300, 13'd4300},
      '{13'd730, 13'd1090, 13'd2440, 13'd3250, 13'd4300},
      '{13'd400, 13'd750,  13'd2500, 13'd3100, 13'd4200},
      '{13'd300, 13'd700,  13'd2260, 13'd3050, 13'd4100}};

endpackage

// ===== hdl/vowel_formant_blend.sv =====
`timescale 1ns / 1ps
// Top level of the vowel formant blend: inverse distance weighting of five vowel anchors.
// Depends on vfb_pkg, vfb_div_chain and vfb_div_cell.
//
//   Channel  Direction  Word
//   req_     in         tdata[15:0] pos_front, tdata[31:16] pos_open
//   rsp_     out        tdata: formant_one (lowest 16 bits) .. formant_five (highest)
//   csr_     in         csr_wr_data[0] male_voice, written when csr_wr_en is high
//
// The block takes one word per cycle while req_tready is high. Most of its
// pipeline is the two rows of divider cells, which settle one quotient bit per
// cycle: forty bits for each anchor weight and seventeen for each blended
// formant. Reset clears the pipeline valid bits, the output and skid valid
// flags and the voice select. When the result side stalls, the output register
// holds one word and a skid register catches the next; while the skid register
// is full the whole pipeline freezes and req_tready is low.
module vowel_formant_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_wr_data,    // male_voice
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,      // pos_front, pos_open
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata       // formant_one .. formant_five
);

   localparam int NA       = vfb_pkg::ANCHORS;
   localparam int NF       = vfb_pkg::FORMANTS;
   localparam int MALE_LAT = 2 + vfb_pkg::W_W;
   localparam int VLD_LAT  = MALE_LAT + 4 + vfb_pkg::Q2_W;
   localparam int OUT_BITS = NF * vfb_pkg::OUT_W;

   logic male_voice_ff;
   logic pipe_en;
   logic skid_valid_ff;
   logic out_valid_ff;
   logic [OUT_BITS-1:0] out_data_ff;
   logic [OUT_BITS-1:0] skid_data_ff;
   logic [OUT_BITS-1:0] pipe_data;

   logic vld_ff  [VLD_LAT+1];
   logic male_ff [MALE_LAT+1];

   logic [vfb_pkg::COORD_W-1:0] pos_x_in, pos_y_in, pos_x_ff, pos_y_ff;
   logic [vfb_pkg::COORD_W-1:0] dx_in [NA];
   logic [vfb_pkg::COORD_W-1:0] dy_in [NA];
   logic [31:0]                 sqx_full [NA];
   logic [31:0]                 sqy_full [NA];
   logic [vfb_pkg::SQ_W-1:0]    sqx_ff [NA];
   logic [vfb_pkg::SQ_W-1:0]    sqy_ff [NA];
   logic [vfb_pkg::DEN_W-1:0]   den_ff [NA];
   logic [vfb_pkg::W_W-1:0]     weight [NA];

   logic [vfb_pkg::HZ8_W-1:0]   hz8_in  [NF][NA];
   logic [vfb_pkg::PROD_W-1:0]  prod_ff [NF][NA];
   logic [vfb_pkg::W_W:0]       tot_a_ff, tot_b_ff;
   logic [vfb_pkg::W_W-1:0]     w4_ff;
   logic [vfb_pkg::TOT_W-1:0]   total2_ff, total3_ff, total4_ff;
   logic [vfb_pkg::PROD_W:0]    s01_ff [NF];
   logic [vfb_pkg::PROD_W:0]    s23_ff [NF];
   logic [vfb_pkg::PROD_W-1:0]  p4_ff  [NF];
   logic [vfb_pkg::PROD_W+1:0]  s0123_ff [NF];
   logic [vfb_pkg::PROD_W:0]    p4h_ff [NF];
   logic [vfb_pkg::NUM_W-1:0]   num_ff [NF];
   logic [vfb_pkg::Q2_W-1:0]    quo [NF];

   // The user must write the voice select only while the block is idle; the block
   // does not enforce this. Each word still carries the value it was accepted with.
   always_ff @(posedge clock) begin
      if (reset) begin
         male_voice_ff <= 1'b0;
      end else if (csr_wr_en) begin
         male_voice_ff <= csr_wr_data[0];
      end
   end

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   // Valid bits and the voice bit travel beside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= VLD_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k <= VLD_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         male_ff[0] <= male_voice_ff;
         for (int k = 1; k <= MALE_LAT; k++) begin
            male_ff[k] <= male_ff[k-1];
         end
      end
   end

   // Input stage: coordinates above one are clamped to one.
   always_comb begin
      pos_x_in = (req_tdata[15:0] > vfb_pkg::UNIT_Q15) ? vfb_pkg::UNIT_Q15 : req_tdata[15:0];
      pos_y_in = (req_tdata[31:16] > vfb_pkg::UNIT_Q15) ? vfb_pkg::UNIT_Q15 : req_tdata[31:16];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // Squared distances to every anchor, exact in Q2.30.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         dx_in[i] = (pos_x_ff >= vfb_pkg::ANCHOR_X[i]) ? pos_x_ff - vfb_pkg::ANCHOR_X[i]
                                                       : vfb_pkg::ANCHOR_X[i] - pos_x_ff;
         dy_in[i] = (pos_y_ff >= vfb_pkg::ANCHOR_Y[i]) ? pos_y_ff - vfb_pkg::ANCHOR_Y[i]
                                                       : vfb_pkg::ANCHOR_Y[i] - pos_y_ff;
         sqx_full[i] = dx_in[i] * dx_in[i];
         sqy_full[i] = dy_in[i] * dy_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < NA; i++) begin
            sqx_ff[i] <= sqx_full[i][vfb_pkg::SQ_W-1:0];
            sqy_ff[i] <= sqy_full[i][vfb_pkg::SQ_W-1:0];
            den_ff[i] <= {1'b0, sqx_ff[i]} + {1'b0, sqy_ff[i]} + vfb_pkg::EPS_Q30;
         end
      end
   end

   // Each weight is 2^62 divided by the distance term, one bit per cell.
   for (genvar i = 0; i < NA; i++) begin : g_weight
      vfb_div_chain #(.QW(vfb_pkg::W_W), .DW(vfb_pkg::DEN_W)) u_weight_div (
         .clock   (clock),
         .enable  (pipe_en),
         .rem_in  (vfb_pkg::DIV1_REM),
         .low_in  ({vfb_pkg::W_W{1'b0}}),
         .div_in  (den_ff[i]),
         .quo_out (weight[i])
      );
   end

   // Formant table lookup in Q13.3 for the voice carried with this word.
   always_comb begin
      for (int f = 0; f < NF; f++) begin
         for (int i = 0; i < NA; i++) begin
            hz8_in[f][i] = male_ff[MALE_LAT] ? {vfb_pkg::MALE_HZ[i][f], 3'b000}
                                             : {vfb_pkg::FEMALE_HZ[i][f], 3'b000};
         end
      end
   end

   // Products, then a registered adder tree. Half the total is added before
   // the final division so that the quotient rounds to nearest, halves up.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int f = 0; f < NF; f++) begin
            for (int i = 0; i < NA; i++) begin
               prod_ff[f][i] <= weight[i] * hz8_in[f][i];
            end
            s01_ff[f]   <= {1'b0, prod_ff[f][0]} + {1'b0, prod_ff[f][1]};
            s23_ff[f]   <= {1'b0, prod_ff[f][2]} + {1'b0, prod_ff[f][3]};
            p4_ff[f]    <= prod_ff[f][4];
            s0123_ff[f] <= {1'b0, s01_ff[f]} + {1'b0, s23_ff[f]};
            p4h_ff[f]   <= {1'b0, p4_ff[f]}
                           + (vfb_pkg::PROD_W+1)'(total2_ff[vfb_pkg::TOT_W-1:1]);
            num_ff[f]   <= {1'b0, s0123_ff[f]} + (vfb_pkg::NUM_W)'(p4h_ff[f]);
         end
         tot_a_ff  <= {1'b0, weight[0]} + {1'b0, weight[1]};
         tot_b_ff  <= {1'b0, weight[2]} + {1'b0, weight[3]};
         w4_ff     <= weight[4];
         total2_ff <= (vfb_pkg::TOT_W)'(tot_a_ff) + (vfb_pkg::TOT_W)'(tot_b_ff)
                      + (vfb_pkg::TOT_W)'(w4_ff);
         total3_ff <= total2_ff;
         total4_ff <= total3_ff;
      end
   end

   // Normalization: rounded weighted sum divided by the total weight.
   for (genvar f = 0; f < NF; f++) begin : g_blend
      vfb_div_chain #(.QW(vfb_pkg::Q2_W), .DW(vfb_pkg::TOT_W)) u_blend_div (
         .clock   (clock),
         .enable  (pipe_en),
         .rem_in  ({1'b0, num_ff[f][vfb_pkg::NUM_W-1:vfb_pkg::Q2_W]}),
         .low_in  (num_ff[f][vfb_pkg::Q2_W-1:0]),
         .div_in  (total4_ff),
         .quo_out (quo[f])
      );

      // Saturate at the top of the output range.
      assign pipe_data[f*vfb_pkg::OUT_W +: vfb_pkg::OUT_W] =
         quo[f][vfb_pkg::Q2_W-1] ? {vfb_pkg::OUT_W{1'b1}} : quo[f][vfb_pkg::OUT_W-1:0];
   end

   // Output register with a one-word skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_tready || !out_valid_ff) begin
         out_valid_ff <= vld_ff[VLD_LAT];
      end else if (vld_ff[VLD_LAT]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (rsp_tready || !out_valid_ff) begin
         out_data_ff <= pipe_data;
      end else begin
         skid_data_ff <= pipe_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== hdl/vfb_div_cell.sv =====
`timescale 1ns / 1ps
// One cell of a pipelined restoring divider: settles one quotient bit per cycle while enable is high.
// Depends on nothing; instantiated by vfb_div_chain.
module vfb_div_cell #(
   parameter int QW = 40,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] rem_in,
   input  logic [QW-1:0] low_in,
   input  logic [QW-1:0] quo_in,
   input  logic [DW-1:0] div_in,
   output logic [DW-1:0] rem_out,
   output logic [QW-1:0] low_out,
   output logic [QW-1:0] quo_out,
   output logic [DW-1:0] div_out
);

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          take;
   logic [DW-1:0] rem_nxt_in;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] low_ff;
   logic [QW-1:0] quo_ff;
   logic [DW-1:0] div_ff;

   // Bring down the next numerator bit and subtract the divisor when it fits.
   always_comb begin
      trial      = {rem_in, low_in[QW-1]};
      diff       = trial - {1'b0, div_in};
      take       = (trial >= {1'b0, div_in});
      rem_nxt_in = take ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_nxt_in;
         low_ff <= {low_in[QW-2:0], 1'b0};
         quo_ff <= {quo_in[QW-2:0], take};
         div_ff <= div_in;
      end
   end

   assign rem_out = rem_ff;
   assign low_out = low_ff;
   assign quo_out = quo_ff;
   assign div_out = div_ff;

endmodule

// ===== hdl/vfb_div_chain.sv =====
`timescale 1ns / 1ps
// Row of divider cells that yields a QW-bit quotient.
// Depends on vfb_div_cell.
module vfb_div_chain #(
   parameter int QW = 40,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] rem_in,   // numerator bits above the low QW bits
   input  logic [QW-1:0] low_in,   // low QW numerator bits
   input  logic [DW-1:0] div_in,
   output logic [QW-1:0] quo_out
);

   logic [DW-1:0] rem [QW+1];
   logic [QW-1:0] low [QW+1];
   logic [QW-1:0] quo [QW+1];
   logic [DW-1:0] dvs [QW+1];

   assign rem[0] = rem_in;
   assign low[0] = low_in;
   assign quo[0] = {QW{1'b0}};
   assign dvs[0] = div_in;

   for (genvar k = 0; k < QW; k++) begin : g_cell
      vfb_div_cell #(.QW(QW), .DW(DW)) u_cell (
         .clock   (clock),
         .enable  (enable),
         .rem_in  (rem[k]),
         .low_in  (low[k]),
         .quo_in  (quo[k]),
         .div_in  (dvs[k]),
         .rem_out (rem[k+1]),
         .low_out (low[k+1]),
         .quo_out (quo[k+1]),
         .div_out (dvs[k+1])
      );
   end

   assign quo_out = quo[QW];

endmodule
